// ===== sv/pcpd_pkg.sv =====
// Shared types and constants for the patch column post decoder.
`timescale 1ns / 1ps
`default_nettype none

package pcpd_pkg;

    localparam int TEX_SIZE_W   = 11;
    localparam int ORIGIN_W     = 16;
    localparam int COL_W        = 10;
    localparam int BYTE_W       = 8;
    localparam int RGB_W        = 24;
    localparam int ADDR_W       = 20;
    localparam int COLOR_W      = 32;
    localparam int COORD_W      = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_MAX_TEX_SIDE    = 1024;
    localparam int DEF_PALETTE_ENTRIES = 256;

    localparam logic [BYTE_W-1:0]     COL_END      = 8'hFF;
    localparam logic [7:0]            ALPHA_OPAQUE = 8'hFF;
    localparam logic [TEX_SIZE_W-1:0] TEX_SIDE_RST = 11'd64;
    localparam logic [ORIGIN_W-1:0]   ORIGIN_RST   = 16'd0;

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_COLUMN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN   = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        palette_slot;
        logic [RGB_W-1:0]  palette_rgb;
        logic [COL_W-1:0]  column_index;
        logic              column_start;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic               pixel_write;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               column_done;
    } t_out_item;

    // Control flags of the stage between parser and address unit.
    typedef struct packed {
        logic valid;
        logic pixel;
        logic done;
    } t_s1_ctrl;

endpackage

`default_nettype wire

// ===== sv/patch_column_post_decoder.sv =====
// Patch column post decoder: decodes column bytes into clipped texture pixel writes.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one item per transfer,
// either a palette write (req_type 0) or one byte of a patch column stream.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// per input item, in order; palette writes return an all-zero result.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready; write texture size and origins only while the block is idle.
//
// The first stage runs the post parser, clipping and the palette read; the
// result stage after it does the row multiply (row times width plus column).
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the stages behind it
// fill; the input stalls only once both stages are full, so a new item is
// still taken while a finished result waits.
// Reset clears the parser to expect a top-row byte, empties the pipeline and
// loads width and height 64 with origins 0. Palette contents are undefined
// until written; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module patch_column_post_decoder
    import pcpd_pkg::*;
#(
    parameter int MAX_TEX_SIDE    = DEF_MAX_TEX_SIDE,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SIDE_W = $clog2(MAX_TEX_SIDE + 1);
    localparam int EXT_W  = (SIDE_W > TEX_SIZE_W) ? SIDE_W : TEX_SIZE_W;
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [TEX_SIZE_W-1:0] r_tex_w, r_tex_h;
    logic [ORIGIN_W-1:0]   r_x_origin, r_y_origin;

    logic [EXT_W-1:0]  w_ext, h_ext;
    logic [SIDE_W-1:0] tex_w, tex_h;

    logic      s1_load, s2_load, accept;
    t_s1_ctrl  s1_ctrl;
    logic [SIDE_W-1:0] s1_tx, s1_ty, s1_w;
    logic [RGB_W-1:0]  pal_rgb;

    // Saturate oversized texture sides.
    assign w_ext = EXT_W'(r_tex_w);
    assign h_ext = EXT_W'(r_tex_h);
    assign tex_w = (w_ext > EXT_W'(MAX_TEX_SIDE)) ? SIDE_W'(MAX_TEX_SIDE) : SIDE_W'(w_ext);
    assign tex_h = (h_ext > EXT_W'(MAX_TEX_SIDE)) ? SIDE_W'(MAX_TEX_SIDE) : SIDE_W'(h_ext);

    // Each stage advances when the one ahead of it is empty or advancing.
    assign s2_load    = !o_out_valid || !i_out_stall;
    assign s1_load    = !s1_ctrl.valid || s2_load;
    assign accept     = i_in_valid && s1_load;
    assign o_in_stall = !s1_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w    <= TEX_SIDE_RST;
            r_tex_h    <= TEX_SIDE_RST;
            r_x_origin <= ORIGIN_RST;
            r_y_origin <= ORIGIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEX_WIDTH:  r_tex_w    <= i_cfg_data[TEX_SIZE_W-1:0];
                CFG_TEX_HEIGHT: r_tex_h    <= i_cfg_data[TEX_SIZE_W-1:0];
                CFG_X_ORIGIN:   r_x_origin <= i_cfg_data[ORIGIN_W-1:0];
                CFG_Y_ORIGIN:   r_y_origin <= i_cfg_data[ORIGIN_W-1:0];
                default: ;
            endcase
        end
    end

    pcpd_parser #(
        .SIDE_W (SIDE_W)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_load       (s1_load),
        .i_item_valid (i_in_valid),
        .i_item       (i_in_data),
        .i_tex_w      (tex_w),
        .i_tex_h      (tex_h),
        .i_x_origin   (r_x_origin),
        .i_y_origin   (r_y_origin),
        .o_ctrl       (s1_ctrl),
        .o_tx         (s1_tx),
        .o_ty         (s1_ty),
        .o_tex_w      (s1_w)
    );

    pcpd_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_in_data.req_type == REQ_PALETTE)),
        .i_wr_addr (PAL_AW'(i_in_data.palette_slot)),
        .i_wr_data (i_in_data.palette_rgb),
        .i_rd_en   (s1_load),
        .i_rd_addr (PAL_AW'(i_in_data.data_byte)),
        .o_rd_data (pal_rgb)
    );

    pcpd_addr #(
        .SIDE_W (SIDE_W)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s2_load),
        .i_ctrl  (s1_ctrl),
        .i_tx    (s1_tx),
        .i_ty    (s1_ty),
        .i_tex_w (s1_w),
        .i_rgb   (pal_rgb),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sv/pcpd_palette.sv =====
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pcpd_palette
    import pcpd_pkg::*;
#(
    parameter int ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  wire logic [RGB_W-1:0]           i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic      [RGB_W-1:0]           o_rd_data
);

    logic [RGB_W-1:0] r_mem [ENTRIES];
    logic [RGB_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold the read data while the next stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/pcpd_parser.sv =====
// Post parser state machine with clipping; drives the first pipeline stage.
`timescale 1ns / 1ps
`default_nettype none

module pcpd_parser
    import pcpd_pkg::*;
#(
    parameter int SIDE_W = $clog2(DEF_MAX_TEX_SIDE + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic                i_load,
    input  wire logic                i_item_valid,
    input  wire t_in_item            i_item,
    input  wire logic [SIDE_W-1:0]   i_tex_w,
    input  wire logic [SIDE_W-1:0]   i_tex_h,
    input  wire logic [ORIGIN_W-1:0] i_x_origin,
    input  wire logic [ORIGIN_W-1:0] i_y_origin,
    output t_s1_ctrl                 o_ctrl,
    output logic      [SIDE_W-1:0]   o_tx,
    output logic      [SIDE_W-1:0]   o_ty,
    output logic      [SIDE_W-1:0]   o_tex_w
);

    localparam int CMP_W = (SIDE_W > ORIGIN_W) ? SIDE_W : ORIGIN_W;

    typedef enum logic [2:0] {
        PH_TOP,
        PH_LEN,
        PH_PAD,
        PH_PIX,
        PH_END
    } t_phase;

    t_phase            r_phase, n_phase, phase_cur;
    logic [BYTE_W-1:0] r_top, n_top;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_cnt, n_cnt;
    logic [BYTE_W-1:0] cnt_inc;

    t_s1_ctrl          r_ctrl, n_ctrl;
    logic [SIDE_W-1:0] r_tx, r_ty, r_w;

    logic signed [COORD_W-1:0] tx, ty;
    logic                      in_bounds;
    logic                      is_column;

    assign is_column = (i_item.req_type == REQ_COLUMN);
    assign phase_cur = i_item.column_start ? PH_TOP : r_phase;
    assign cnt_inc   = r_cnt + 8'd1;

    // Texture coordinates of the current pixel, before clipping.
    assign tx = $signed({i_x_origin[ORIGIN_W-1], i_x_origin})
              + $signed(COORD_W'(i_item.column_index));
    assign ty = $signed({i_y_origin[ORIGIN_W-1], i_y_origin})
              + $signed(COORD_W'(r_top)) + $signed(COORD_W'(r_cnt));

    assign in_bounds = !tx[COORD_W-1] && !ty[COORD_W-1]
                    && (CMP_W'(tx[ORIGIN_W-1:0]) < CMP_W'(i_tex_w))
                    && (CMP_W'(ty[ORIGIN_W-1:0]) < CMP_W'(i_tex_h));

    always_comb begin
        n_phase = r_phase;
        n_top   = r_top;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_ctrl  = '{valid: i_item_valid, pixel: 1'b0, done: 1'b0};
        if (is_column) begin
            n_phase = phase_cur;
            unique case (phase_cur)
                PH_LEN: begin
                    n_len   = i_item.data_byte;
                    n_cnt   = '0;
                    n_phase = PH_PAD;
                end
                PH_PAD: begin
                    n_phase = (r_len == '0) ? PH_END : PH_PIX;
                end
                PH_PIX: begin
                    n_ctrl.pixel = in_bounds;
                    n_cnt        = cnt_inc;
                    if (cnt_inc == r_len) begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    n_phase = PH_TOP;
                end
                default: begin
                    if (i_item.data_byte == COL_END) begin
                        n_ctrl.done = 1'b1;
                        n_phase     = PH_TOP;
                    end else begin
                        n_top   = i_item.data_byte;
                        n_phase = PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP;
            r_top   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_ctrl  <= '0;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_top   <= n_top;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
            end
            if (i_load) begin
                r_ctrl <= n_ctrl;
            end
        end
        if (i_load) begin
            r_tx <= SIDE_W'(tx[ORIGIN_W-1:0]);
            r_ty <= SIDE_W'(ty[ORIGIN_W-1:0]);
            r_w  <= i_tex_w;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_tx    = r_tx;
    assign o_ty    = r_ty;
    assign o_tex_w = r_w;

endmodule

`default_nettype wire

// ===== sv/pcpd_addr.sv =====
// Address multiply and result register.
`timescale 1ns / 1ps
`default_nettype none

module pcpd_addr
    import pcpd_pkg::*;
#(
    parameter int SIDE_W = $clog2(DEF_MAX_TEX_SIDE + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_s1_ctrl          i_ctrl,
    input  wire logic [SIDE_W-1:0] i_tx,
    input  wire logic [SIDE_W-1:0] i_ty,
    input  wire logic [SIDE_W-1:0] i_tex_w,
    input  wire logic [RGB_W-1:0]  i_rgb,
    output logic                   o_valid,
    output t_out_item              o_item
);

    localparam int PW = 2 * SIDE_W + 1;

    logic [PW-1:0] mac;
    logic          r_valid;
    t_out_item     r_item, n_item;

    assign mac = PW'(i_ty) * PW'(i_tex_w) + PW'(i_tx);

    always_comb begin
        n_item = '0;
        n_item.column_done = i_ctrl.done;
        if (i_ctrl.pixel) begin
            n_item.pixel_write   = 1'b1;
            n_item.pixel_address = ADDR_W'(mac);
            n_item.pixel_color   = {ALPHA_OPAQUE, i_rgb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_ctrl.valid;
        end
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== sv/pcpd_checker.sv =====
// Port-level checks for the patch column post decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcpd_checker
    import pcpd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // A stalled input transfer keeps its valid and payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input changed");

    // Results without a pixel carry zero address and color.
    a_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pixel_write
            |-> (o_out_data.pixel_address == '0) && (o_out_data.pixel_color == '0))
        else $error("pixel fields nonzero without a pixel write");

    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_write
            |-> o_out_data.pixel_color[COLOR_W-1 -: 8] == ALPHA_OPAQUE)
        else $error("pixel color not opaque");

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.pixel_write && o_out_data.column_done))
        else $error("terminator result also wrote a pixel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind patch_column_post_decoder pcpd_checker u_pcpd_checker (.*);

`default_nettype wire
